### sv/swm_pkg.sv
// Shared types and constants for the sliding window maximum core.
// Used by every module of the block; depends on nothing.
package swm_pkg;

    localparam int SAMPLE_W = 32;   // sample and result width
    localparam int IDX_W    = 32;   // sample counter and entry index width
    localparam int WS_W     = 7;    // window_size register width
    localparam int CFG_W    = 32;   // APB data width
    localparam int ADDR_W   = 3;    // APB address width

    // Register index taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_WINDOW_SIZE   = 1'b0;
    localparam logic [WS_W-1:0]   WINDOW_SIZE_RESET = 7'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic                       last_result;
    } t_out_beat;

    // One deque entry held by a cell
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]           index;
    } t_entry;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic   step;    // a sample is pushed this cycle
        logic   clear;   // empty the chain after this cycle
        logic   shift;   // front entry leaves, everything moves one cell forward
        t_entry fresh;   // the entry made from the new sample
    } t_cell_ctl;

endpackage

### sv/swm_cell.sv
// One cell of the deque chain: holds a single (index, value) entry.
// Depends on swm_pkg; talks only to its two neighbors.
module swm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swm_pkg::t_cell_ctl i_ctl,
    input  logic              i_head,        // this cell is the deque front
    input  logic              i_left_keep,   // front neighbor survives (1 at the front)
    input  logic              i_right_keep,  // rear neighbor survives
    input  swm_pkg::t_entry   i_right,       // rear neighbor's entry
    output swm_pkg::t_entry   o_entry,
    output logic              o_keep
);
    import swm_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Survive the rear drop only while strictly above the new sample
    assign o_keep  = r_entry.valid && (r_entry.value > i_ctl.fresh.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry       = r_entry;
        n_entry.valid = 1'b0;
        if (i_ctl.shift) begin
            if (i_right_keep) begin
                n_entry = i_right;
            end else if (o_keep || i_head) begin
                n_entry = i_ctl.fresh;
            end
        end else begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_ctl.fresh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_entry.valid <= 1'b0;
        end else if (i_ctl.step) begin
            r_entry <= n_entry;
        end
    end

endmodule

### sv/swm_out_buf.sv
// Two-beat result buffer between the deque chain and the output channel.
// Depends on swm_pkg for the result beat type.
module swm_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  swm_pkg::t_out_beat i_beat,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output swm_pkg::t_out_beat o_beat
);
    import swm_pkg::*;

    t_out_beat  r_slot0;
    t_out_beat  r_slot1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_beat  = r_slot0;
    assign o_space = (r_cnt != 2'd2);
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_cnt == 2'd2) begin
            r_slot0 <= r_slot1;
            if (i_push) begin
                r_slot1 <= i_beat;
            end
        end else if (w_pop) begin
            if (i_push) begin
                r_slot0 <= i_beat;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_slot0 <= i_beat;
            end else begin
                r_slot1 <= i_beat;
            end
        end
    end

endmodule

### sv/sliding_window_max_core.sv
// Top level of the sliding window maximum core: APB register, control,
// the chain of swm_cell deque cells and the swm_out_buf result buffer.
// Depends on swm_pkg, swm_cell and swm_out_buf.
//
//   channel   direction  handshake                    beat
//   input     in         i_in_valid / o_in_ready      swm_pkg::t_in_beat
//   output    out        o_out_valid / i_out_ready    swm_pkg::t_out_beat
//   config    in         psel, penable, pwrite, pready  window_size at 0x0
//
// One sample is taken per cycle while the buffer has space; its result, if any, is
// registered into a two-beat buffer that drives the output.
// All deque work for a sample (age-out, rear drops, append) happens in the
// cell chain in the cycle the sample is taken; the front cell holds the window maximum.
// o_in_ready drops only while both buffer slots hold unclaimed beats.
// Reset (synchronous, active low) empties the chain and the buffer, zeroes
// the sample count and sets window_size to 1; no clearing pass is needed.
module sliding_window_max_core #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  swm_pkg::t_in_beat           i_in_beat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output swm_pkg::t_out_beat          o_out_beat,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]  paddr,
    input  logic [swm_pkg::CFG_W-1:0]   pwdata,
    output logic [swm_pkg::CFG_W-1:0]   prdata,
    output logic                        pready
);
    import swm_pkg::*;

    localparam logic [IDX_W-1:0] CAP = IDX_W'(WINDOW_MAX);

    logic [WS_W-1:0]  r_window_size;
    logic [IDX_W-1:0] r_sample_count;

    t_entry           w_entry [0:WINDOW_MAX];
    logic [WINDOW_MAX:0] w_keep;
    t_cell_ctl        w_ctl;
    t_out_beat        w_res;

    logic [IDX_W-1:0] w_ws_ext;
    logic [IDX_W-1:0] w_k;
    logic [IDX_W-1:0] w_age;
    logic             w_accept;
    logic             w_aged;
    logic             w_all_keep;
    logic             w_produce;
    logic             w_push;
    logic             w_space;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1:2] == REG_WINDOW_SIZE) begin
            r_window_size <= pwdata[WS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE) begin
            prdata = CFG_W'(r_window_size);
        end
    end

    // ---------------- control ----------------
    assign o_in_ready = w_space;
    assign w_accept   = i_in_valid && o_in_ready;

    // Saturate the window to the chain length
    assign w_ws_ext = IDX_W'(r_window_size);
    assign w_k      = (w_ws_ext > CAP) ? CAP : w_ws_ext;

    // Age out at most one front entry per sample (wrapping difference)
    assign w_age  = r_sample_count - w_entry[0].index;
    assign w_aged = w_entry[0].valid && (w_age >= w_k);

    // Every cell survives the rear drop: chain is full, drop the front
    assign w_all_keep = &w_keep[WINDOW_MAX-1:0];

    assign w_produce = (r_sample_count >= w_k - 1'b1);

    always_comb begin
        w_ctl.step        = w_accept && (w_k != '0);
        w_ctl.clear       = w_accept && ((w_k == '0) || i_in_beat.last_sample);
        w_ctl.shift       = w_aged || w_all_keep;
        w_ctl.fresh.valid = 1'b1;
        w_ctl.fresh.value = i_in_beat.sample;
        w_ctl.fresh.index = r_sample_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
        end else if (w_ctl.clear) begin
            r_sample_count <= '0;
        end else if (w_ctl.step) begin
            r_sample_count <= r_sample_count + 1'b1;
        end
    end

    // ---------------- deque cell chain ----------------
    // Sentinel past the rear: never valid, never kept
    assign w_entry[WINDOW_MAX] = '0;
    assign w_keep[WINDOW_MAX]  = 1'b0;

    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        logic w_left_keep;
        if (j == 0) begin : g_front
            assign w_left_keep = 1'b1;
        end else begin : g_rest
            assign w_left_keep = w_keep[j-1];
        end

        swm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_head       (1'(j == 0)),
            .i_left_keep  (w_left_keep),
            .i_right_keep (w_keep[j+1]),
            .i_right      (w_entry[j+1]),
            .o_entry      (w_entry[j]),
            .o_keep       (w_keep[j])
        );
    end

    // Front value after this sample's push: same choice the front cell makes
    always_comb begin
        if (w_ctl.shift) begin
            w_res.window_max = w_keep[1] ? w_entry[1].value : i_in_beat.sample;
        end else begin
            w_res.window_max = w_keep[0] ? w_entry[0].value : i_in_beat.sample;
        end
        w_res.last_result = i_in_beat.last_sample;
    end

    // Results start once the window has filled
    assign w_push = w_ctl.step && w_produce;

    // ---------------- result buffer ----------------
    swm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_beat  (w_res),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

endmodule

### sv/swm_checker.sv
// Port-level checks for sliding_window_max_core, bound to the top level.
// Depends on swm_pkg for the beat types.
module swm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input swm_pkg::t_out_beat o_out_beat,
    input logic               pready
);
    import swm_pkg::*;

    // Hold a stalled result beat unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat dropped or changed while stalled");

    // Input stalls only when results are backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // Reset empties the result buffer and opens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("buffer not empty after reset");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind sliding_window_max_core swm_checker u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat),
    .pready      (pready)
);

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for sliding_window_max_core: sends signed sample streams, writes window_size
// over APB, predicts every window maximum and checks each output beat.
// Depends on swm_pkg and the core RTL (sliding_window_max_core and its cells).
module tb;
    import swm_pkg::*;

    localparam int DEPTH       = 64;       // deque capacity, matches WINDOW_MAX
    localparam int ITEM_TARGET = 550;      // counted samples before the random part stops
    localparam int MAX_GAP     = 8;        // longest per-beat idle on either side
    localparam int LONG_HOLD   = 300;      // receiver hold-off for the fill-up test
    localparam int SETTLE      = 4;        // cycles past the last beat before a register write
    localparam int CYCLE_LIMIT = 200000;   // hard stop for a hung run

    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // Flavors of sample sequences; falling runs build deep deques, narrow runs make ties.
    typedef enum int {
        MODE_RANDOM,
        MODE_NARROW,
        MODE_EXTREME,
        MODE_FALLING,
        MODE_RISING
    } t_sample_mode;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input has a known value from time 0.
    // ------------------------------------------------------------------
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_beat            in_beat  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_beat           out_beat;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [CFG_W-1:0]    pwdata   = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    // Pacing controls, flipped by the tests per phase.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_req   = 0;     // bump to ask the receiver for one long hold-off
    int hold_ack   = 0;
    int rx_wait    = 0;
    int rx_draw;

    int mismatch_cnt = 0;
    int samples_sent = 0;   // samples the block actually works on (window not zero)
    int cycle_cnt    = 0;

    // ------------------------------------------------------------------
    // Predictor state: a ring of (value, index) entries kept in falling value
    // order from head to tail, the position within the current stream, and
    // the window_size register as last written.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] dq_val [DEPTH];
    logic [IDX_W-1:0]           dq_idx [DEPTH];
    int                         dq_head;
    int                         dq_cnt;
    logic [IDX_W-1:0]           stream_pos;
    logic [WS_W-1:0]            win_reg;
    t_out_beat                  pending_max [$];   // window maxima still to come out

    sliding_window_max_core #(
        .WINDOW_MAX (DEPTH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endfunction

    function automatic void clear_stream_state();
        dq_head    = 0;
        dq_cnt     = 0;
        stream_pos = '0;
    endfunction

    // Advance the predictor by one sample and queue the window maximum it yields, if any.
    function automatic void predict_window_max(input logic signed [SAMPLE_W-1:0] s,
                                               input logic is_last);
        logic [IDX_W-1:0] span;
        logic [IDX_W-1:0] pos;
        int               tail;
        t_out_beat        res;
        span = (win_reg > DEPTH) ? IDX_W'(DEPTH) : IDX_W'(win_reg);
        pos  = stream_pos;
        // A zero window ignores the sample but still wipes the stream.
        if (span == 0) begin
            clear_stream_state();
            return;
        end
        // Age out at most one front entry; the difference wraps like the counter does.
        if (dq_cnt > 0 && (pos - dq_idx[dq_head]) >= span) begin
            dq_head = (dq_head + 1) % DEPTH;
            dq_cnt--;
        end
        // Drop every rear entry the new sample ties or beats.
        while (dq_cnt > 0 && dq_val[(dq_head + dq_cnt - 1) % DEPTH] <= s) begin
            dq_cnt--;
        end
        // Ring full: make room by dropping the front.
        if (dq_cnt >= DEPTH) begin
            dq_head = (dq_head + 1) % DEPTH;
            dq_cnt--;
        end
        tail         = (dq_head + dq_cnt) % DEPTH;
        dq_val[tail] = s;
        dq_idx[tail] = pos;
        dq_cnt++;
        // Results start once the window has filled within this stream.
        if (pos >= span - 1) begin
            res.window_max  = dq_val[dq_head];
            res.last_result = is_last;
            pending_max.push_back(res);
        end
        stream_pos = pos + 1'b1;
        if (is_last) begin
            clear_stream_state();
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] next_sample(
        input t_sample_mode mode, input logic signed [SAMPLE_W-1:0] prev);
        // Sprinkle full-range values into every flavor.
        if ($urandom_range(0, 9) == 0) return $urandom;
        case (mode)
            MODE_RANDOM:  return $urandom;
            MODE_NARROW:  return int'($urandom_range(0, 6)) - 3;
            MODE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            MODE_FALLING: return prev - int'($urandom_range(0, 50000));
            default:      return prev + int'($urandom_range(0, 50000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side. Enter just after a rising edge; leave just after the edge
    // that took the beat, with valid still high so the next beat can follow
    // back to back.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{sample: s, last_sample: is_last};
        if (win_reg != 0) samples_sent++;
        predict_window_max(s, is_last);
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid, wait for every predicted beat, then give the block time to go idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_max.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write window_size, then go straight into a read of the same register and check it.
    // Upper data bits carry noise; only the low WS_W bits belong to the register.
    task automatic set_window(input logic [WS_W-1:0] w);
        logic [CFG_W-1:0] word;
        word          = $urandom;
        word[WS_W-1:0] = w;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        win_reg = w;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== CFG_W'(w)) begin
            note_mismatch($sformatf("window_size read expected %0d got %0d", w, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side. Draw a stall after each taken beat; a bumped hold_req
    // forces one long hold-off regardless of traffic.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
            hold_ack  <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            rx_wait   <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait   <= rx_wait - 1;
            out_ready <= (rx_wait == 1);
        end else if (out_valid && out_ready) begin
            rx_draw = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            rx_wait   <= rx_draw;
            out_ready <= (rx_draw == 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compare every taken output beat with the oldest predicted maximum.
    always @(posedge clk) begin : check_beat
        t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_max.size() == 0) begin
                note_mismatch($sformatf("unexpected beat window_max=%0d last_result=%0b",
                                        out_beat.window_max, out_beat.last_result));
            end else begin
                want = pending_max.pop_front();
                if (out_beat.window_max !== want.window_max) begin
                    note_mismatch($sformatf("window_max expected %0d got %0d",
                                            want.window_max, out_beat.window_max));
                end
                if (out_beat.last_result !== want.last_result) begin
                    note_mismatch($sformatf("last_result expected %0b got %0b",
                                            want.last_result, out_beat.last_result));
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the window is one sample wide: every sample is its own maximum.
    task automatic test_reset_window();
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed_cases();
        // Ties evict older entries; the 7 ages out as the closing minimum arrives.
        set_window(7'd3);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(7, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(S_MIN, 1'b1);
        wait_idle();
        // Stream ends before the window fills: no beat and no last flag.
        set_window(7'd5);
        send_sample(1, 1'b0);
        send_sample(2, 1'b1);
        wait_idle();
        // Zero window: samples go nowhere.
        set_window(7'd0);
        send_sample(9, 1'b0);
        send_sample(10, 1'b1);
        wait_idle();
        // Shrink the window in the middle of a falling stream; results lag as the
        // front drains one entry per sample.
        set_window(7'd4);
        send_sample(100, 1'b0);
        send_sample(90, 1'b0);
        send_sample(80, 1'b0);
        send_sample(70, 1'b0);
        send_sample(60, 1'b0);
        send_sample(50, 1'b0);
        wait_idle();
        set_window(7'd2);
        send_sample(40, 1'b0);
        send_sample(30, 1'b1);
        wait_idle();
    endtask

    // Hold the output off for a long stretch while samples keep coming, so the
    // result buffer fills and the block has to stall its input.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_window(7'd1);
        hold_req++;
        for (int n = 0; n < 40; n++) begin
            send_sample($urandom, n == 39);
        end
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // One phase: pick a window (largest and above-capacity first), then send a few
    // streams. Some streams end early, and now and then the last one stays open so
    // the next phase changes the window mid-stream.
    task automatic run_random_phase(input int phase);
        logic [WS_W-1:0]            w;
        int                         span;
        int                         n_streams;
        int                         len;
        int                         pick;
        bit                         leave_open;
        t_sample_mode               mode;
        logic signed [SAMPLE_W-1:0] v;
        if (phase == 0) begin
            w = 7'd64;
        end else if (phase == 1) begin
            w = 7'd127;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      w = WS_W'($urandom_range(1, 8));
            else if (pick < 70) w = WS_W'($urandom_range(9, 63));
            else if (pick < 80) w = 7'd64;
            else if (pick < 88) w = WS_W'($urandom_range(65, 127));
            else if (pick < 94) w = 7'd0;
            else                w = WS_W'($urandom_range(1, 3));
        end
        set_window(w);
        span       = (w > DEPTH) ? DEPTH : int'(w);
        // Leave each side free-running in about one phase out of four.
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        n_streams  = (span > 16) ? 1 : $urandom_range(1, 3);
        v          = $urandom;
        for (int st = 0; st < n_streams; st++) begin
            if (span == 0)
                len = $urandom_range(1, 4);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, (span > 1) ? span - 1 : 1);
            else
                len = span + $urandom_range(0, span + 8);
            mode       = t_sample_mode'($urandom_range(0, 4));
            leave_open = (st == n_streams - 1) && ($urandom_range(0, 7) == 0);
            for (int n = 0; n < len; n++) begin
                v = next_sample(mode, v);
                send_sample(v, (n == len - 1) && !leave_open);
            end
        end
        wait_idle();
    endtask

    task automatic test_random_streams();
        int phase;
        phase = 0;
        while (samples_sent < ITEM_TARGET) begin
            run_random_phase(phase);
            phase++;
        end
    endtask

    initial begin
        win_reg = WINDOW_SIZE_RESET;
        clear_stream_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_directed_cases();
        test_backpressure();
        test_random_streams();
        wait_idle();
        repeat (2 * SETTLE) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
